// ----- rtl/dvk_pkg.sv -----
// ----------------------------------------------------------------------------
// dvk_pkg
// Shared types and constants for the delta varint k-mer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dvk_pkg;

   localparam int unsigned FRAG_WIDTH        = 16;
   localparam int unsigned KMER_WIDTH        = 64;
   localparam int unsigned GROUP_BITS        = 15;
   localparam int unsigned STOP_BIT_POS      = 15;
   localparam int unsigned COUNT_WIDTH       = 3;
   localparam int unsigned MAX_WORDS_DEFAULT = 5;

   typedef struct packed {
      logic [FRAG_WIDTH-1:0] fragment;
      logic                  restart;
   } req_type;

   typedef struct packed {
      logic [KMER_WIDTH-1:0] kmer_value;
      logic                  too_long;
   } rsp_type;

   // Result handed from the decode stage to the output register.
   typedef struct packed {
      logic    emit;
      rsp_type data;
   } core_result_type;

endpackage

`default_nettype wire

// ----- rtl/dvk_core.sv -----
// ----------------------------------------------------------------------------
// dvk_core
// Decode stage: accumulates payload groups, adds the finished difference to
// the previous k-mer and keeps the running decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

module dvk_core #(
   parameter int unsigned MAX_WORDS = dvk_pkg::MAX_WORDS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     item_valid,
   input  wire dvk_pkg::req_type   item_data,
   input  wire                     res_free,
   output logic                    item_take,
   output dvk_pkg::core_result_type result
);
   import dvk_pkg::*;

   localparam logic [COUNT_WIDTH:0] MaxWords = (COUNT_WIDTH+1)'(MAX_WORDS);

   logic [KMER_WIDTH-1:0]  acc_ff,  acc_in;
   logic [KMER_WIDTH-1:0]  prev_ff, prev_in;
   logic [COUNT_WIDTH-1:0] cnt_ff,  cnt_in;

   logic [KMER_WIDTH-1:0]  acc_cur;
   logic [KMER_WIDTH-1:0]  prev_cur;
   logic [COUNT_WIDTH-1:0] cnt_cur;
   logic [COUNT_WIDTH:0]   count;
   logic [KMER_WIDTH-1:0]  merged;
   logic [KMER_WIDTH-1:0]  shifted;
   logic [KMER_WIDTH-1:0]  addend;
   logic [KMER_WIDTH-1:0]  sum;
   logic                   stop;
   logic                   overlong;
   logic                   emit;

   always_comb begin
      // restart drops any partial difference and the previous value
      acc_cur  = item_data.restart ? '0 : acc_ff;
      prev_cur = item_data.restart ? '0 : prev_ff;
      cnt_cur  = item_data.restart ? '0 : cnt_ff;
      count    = {1'b0, cnt_cur} + (COUNT_WIDTH+1)'(1);
      stop     = item_data.fragment[STOP_BIT_POS];
      merged   = acc_cur | KMER_WIDTH'(item_data.fragment[GROUP_BITS-1:0]);
      shifted  = merged << GROUP_BITS;
      overlong = !stop && (count >= MaxWords);
      emit     = stop || overlong;
      addend   = stop ? merged : shifted;
      sum      = prev_cur + addend;
   end

   // Words that yield no result never wait on the output side.
   assign item_take = item_valid && (!emit || res_free);

   always_comb begin
      acc_in  = acc_ff;
      prev_in = prev_ff;
      cnt_in  = cnt_ff;
      if (item_take) begin
         if (emit) begin
            acc_in  = '0;
            cnt_in  = '0;
            prev_in = sum;
         end else begin
            acc_in  = shifted;
            cnt_in  = count[COUNT_WIDTH-1:0];
            prev_in = prev_cur;
         end
      end
   end

   always_comb begin
      result.emit            = item_take && emit;
      result.data.kmer_value = sum;
      result.data.too_long   = overlong;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/dvk_out.sv -----
// ----------------------------------------------------------------------------
// dvk_out
// Result register: holds a decoded k-mer until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dvk_out (
   input  wire                      clock,
   input  wire                      reset,
   input  wire dvk_pkg::core_result_type result,
   output logic                     res_free,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output dvk_pkg::rsp_type         rsp_data
);
   import dvk_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   // free when empty or when the held result transfers this cycle
   assign res_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (result.emit) begin
         valid_in = 1'b1;
         data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/delta_varint_kmer_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// delta_varint_kmer_decoder_unit
// Rebuilds sorted 64-bit k-mers from a stream of 15-bit difference groups.
// ----------------------------------------------------------------------------
// The unit takes one coded word per cycle and sustains that rate with no
// bubbles while the result side keeps up. A word passes an input register,
// then the decode stage ORs its group into the accumulator and, on a stop
// word or on the MAX_WORDS-th word without one, adds the difference to the
// previous k-mer in a single 64-bit add that sets the critical path; the sum
// lands in the result register on the edge after the decode stage takes its
// last word, so rsp_valid rises in the cycle after that take. Words that finish
// no difference are absorbed even while a result is held.
`default_nettype none

module delta_varint_kmer_decoder_unit #(
   parameter int unsigned MAX_WORDS = dvk_pkg::MAX_WORDS_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire dvk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output dvk_pkg::rsp_type rsp_data
);
   import dvk_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff,  in_data_in;
   logic            item_take;
   logic            res_free;
   logic            req_take;
   core_result_type result;

   assign req_stall = in_valid_ff && !item_take;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff && !item_take;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   dvk_core #(
      .MAX_WORDS(MAX_WORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_data  (in_data_ff),
      .res_free   (res_free),
      .item_take  (item_take),
      .result     (result)
   );

   dvk_out u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .res_free  (res_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/dvk_checker.sv -----
// ----------------------------------------------------------------------------
// dvk_checker
// Port-level checks for the delta varint k-mer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module dvk_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire dvk_pkg::req_type req_data,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input wire dvk_pkg::rsp_type rsp_data
);
   import dvk_pkg::*;

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // a stop word yields its result via the input and result registers when the output drains
   a_stop_emits: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.fragment[STOP_BIT_POS] ##1 !rsp_stall
      |=> rsp_valid)
      else $error("stop word gave no result");

   // a restart stop word decodes to its own payload
   a_restart_value: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.restart && req_data.fragment[STOP_BIT_POS]
      ##1 !rsp_stall
      |=> rsp_data.kmer_value == KMER_WIDTH'($past(req_data.fragment[GROUP_BITS-1:0], 2))
          && !rsp_data.too_long)
      else $error("restart value mismatch");

endmodule

bind delta_varint_kmer_decoder_unit dvk_checker u_dvk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- dv/delta_varint_kmer_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_varint_kmer_decoder_unit_tb
// Checks the k-mer decoder against a cycle-free model of the difference list.
// Coded words go in through the request channel with random gaps. Each
// transferred word updates a local copy of the accumulator, the word count
// and the previous k-mer, and queues the k-mer it should produce. Every
// result transfer is compared field by field with the oldest queued k-mer.
// The result side stalls at random, and once holds off long enough to
// back the unit up into its input.
// ----------------------------------------------------------------------------

module delta_varint_kmer_decoder_unit_tb;

   import dvk_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Decoder state as the unit should hold it after each transferred word.
   logic [KMER_WIDTH-1:0] diff_acc  = '0;
   logic [KMER_WIDTH-1:0] prev_kmer = '0;
   int                    words_held = 0;
   rsp_type               pending_kmers[$];

   // Idling control: idle_on is shared by both sides, the rest drive the result side.
   logic idle_on      = 1'b1;
   int   hold_request = 0;
   int   hold_left    = 0;
   int   stall_left   = 0;
   int   stall_gap;

   int      fail_count      = 0;
   int      words_sent      = 0;
   int      kmers_checked   = 0;
   int      overlong_seen   = 0;
   int      restarts_seen   = 0;
   int      input_stall_run = 0;
   int      longest_stall   = 0;
   rsp_type wanted;

   delta_varint_kmer_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [GROUP_BITS-1:0] random_group();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return GROUP_BITS'($urandom);
   endfunction

   // Apply one transferred word to the local state; queue the k-mer it closes.
   task automatic decode_word(input req_type item);
      logic [KMER_WIDTH-1:0] group;
      int                    count;
      rsp_type               kmer;
      group = '0;
      group[GROUP_BITS-1:0] = item.fragment[GROUP_BITS-1:0];
      if (item.restart) begin
         diff_acc   = '0;
         words_held = 0;
         prev_kmer  = '0;
         restarts_seen++;
      end
      count = words_held + 1;
      if (item.fragment[STOP_BIT_POS]) begin
         prev_kmer       = prev_kmer + (diff_acc | group);
         diff_acc        = '0;
         words_held      = 0;
         kmer.kmer_value = prev_kmer;
         kmer.too_long   = 1'b0;
         pending_kmers   = {pending_kmers, kmer};
      end else begin
         diff_acc = (diff_acc | group) << GROUP_BITS;
         if (count >= MAX_WORDS_DEFAULT) begin
            // overlong difference: add the already shifted accumulator
            prev_kmer       = prev_kmer + diff_acc;
            diff_acc        = '0;
            words_held      = 0;
            kmer.kmer_value = prev_kmer;
            kmer.too_long   = 1'b1;
            pending_kmers   = {pending_kmers, kmer};
            overlong_seen++;
         end else begin
            words_held = count;
         end
      end
   endtask

   // Offer one word, hold it until transferred, then idle for a random gap while idling is on.
   task automatic push_word(input logic stop, input logic [GROUP_BITS-1:0] group,
                            input logic restart);
      int      gap;
      req_type item;
      item.fragment = {stop, group};
      item.restart  = restart;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      decode_word(item);
      words_sent++;
      gap = idle_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic pause_requests(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_kmers();
      while (pending_kmers.size() != 0) @(posedge clock);
   endtask

   task automatic test_single_word_kmers();
      push_word(1'b1, 15'h0000, 1'b0);
      push_word(1'b1, 15'h7fff, 1'b0);
      push_word(1'b1, 15'h5555, 1'b0);
      push_word(1'b1, 15'h2aaa, 1'b0);
      pause_requests(1);
   endtask

   task automatic test_longest_difference();
      // four continuation words, stop on the fifth: the longest legal difference
      repeat (4) push_word(1'b0, 15'h7fff, 1'b0);
      push_word(1'b1, 15'h7fff, 1'b0);
      pause_requests(1);
   endtask

   task automatic test_overlong_difference();
      // two overlong runs in a row push the sum past 2^64
      repeat (5) push_word(1'b0, 15'h7fff, 1'b0);
      repeat (5) push_word(1'b0, 15'h7fff, 1'b0);
      push_word(1'b0, 15'h0001, 1'b0);
      repeat (4) push_word(1'b0, 15'h0000, 1'b0);
      pause_requests(1);
   endtask

   task automatic test_restart();
      push_word(1'b0, 15'h1234, 1'b1);
      push_word(1'b1, 15'h0001, 1'b1);
      push_word(1'b0, 15'h0010, 1'b0);
      push_word(1'b1, 15'h7fff, 1'b1);
      pause_requests(1);
   endtask

   task automatic test_result_hold_off();
      idle_on      = 1'b0;
      hold_request = 200;
      repeat (40) push_word(1'b1, random_group(), 1'b0);
      pause_requests(1);
      drain_kmers();
      idle_on = 1'b1;
   endtask

   task automatic test_random_lists(input int word_budget);
      int sent;
      int kind;
      int tail;
      sent = 0;
      while (sent < word_budget) begin
         if ($urandom_range(0, 29) == 0) begin
            // switch idling off for a stretch now and then
            idle_on = ($urandom_range(0, 3) != 0);
            pause_requests(1);
         end
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            tail = $urandom_range(0, MAX_WORDS_DEFAULT - 1);
            for (int w = 0; w < tail; w++)
               push_word(1'b0, random_group(), w == 0 && $urandom_range(0, 24) == 0);
            push_word(1'b1, random_group(), tail == 0 && $urandom_range(0, 24) == 0);
            sent += tail + 1;
         end else if (kind < 85) begin
            for (int w = 0; w < MAX_WORDS_DEFAULT; w++)
               push_word(1'b0, random_group(), 1'b0);
            sent += MAX_WORDS_DEFAULT;
         end else if (kind < 92) begin
            // broken difference: dropped by a restart on the next word
            tail = $urandom_range(1, MAX_WORDS_DEFAULT - 1);
            for (int w = 0; w < tail; w++)
               push_word(1'b0, random_group(), 1'b0);
            push_word(1'($urandom_range(0, 1)), random_group(), 1'b1);
            sent += tail + 1;
         end else begin
            push_word(1'($urandom_range(0, 1)), GROUP_BITS'($urandom),
                      1'($urandom_range(0, 1)));
            sent++;
         end
      end
      idle_on = 1'b1;
      pause_requests(1);
   endtask

   // Result side: random stalls, plus a counted hold-off on request.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_gap = idle_length();
         rsp_stall <= (stall_gap > 0);
         if (stall_gap > 0) stall_left = stall_gap - 1;
      end
   end

   always @(posedge clock) begin
      if (req_valid && req_stall) begin
         input_stall_run++;
         if (input_stall_run > longest_stall) longest_stall = input_stall_run;
      end else begin
         input_stall_run = 0;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_kmers.size() == 0) begin
            $display("%0t: unexpected k-mer transfer: kmer_value %h too_long %b",
                     $time, rsp_data.kmer_value, rsp_data.too_long);
            fail_count++;
         end else begin
            wanted = pending_kmers.pop_front();
            if (rsp_data.kmer_value !== wanted.kmer_value) begin
               $display("%0t: kmer_value mismatch: expected %h, actual %h",
                        $time, wanted.kmer_value, rsp_data.kmer_value);
               fail_count++;
            end
            if (rsp_data.too_long !== wanted.too_long) begin
               $display("%0t: too_long mismatch: expected %b, actual %b",
                        $time, wanted.too_long, rsp_data.too_long);
               fail_count++;
            end
            kmers_checked++;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_word_kmers();
      test_longest_difference();
      test_overlong_difference();
      test_restart();
      test_result_hold_off();
      test_random_lists(690);
      drain_kmers();
      repeat (8) @(posedge clock);
      $display("Sent %0d coded words with %0d restarts; checked %0d k-mers, %0d overlong.",
               words_sent, restarts_seen, kmers_checked, overlong_seen);
      $display("Longest input stall under result hold-off: %0d cycles.", longest_stall);
      if (fail_count == 0) begin
         $display("delta_varint_kmer_decoder_unit_tb: PASS");
      end else begin
         $display("delta_varint_kmer_decoder_unit_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("%0t: run timed out with %0d k-mers outstanding", $time, pending_kmers.size());
      $display("delta_varint_kmer_decoder_unit_tb: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dvk_pkg.sv
rtl/dvk_core.sv
rtl/dvk_out.sv
rtl/delta_varint_kmer_decoder_unit.sv
rtl/dvk_checker.sv
dv/delta_varint_kmer_decoder_unit_tb.sv
